// ----- rtl/rpq_pkg.sv -----
package rpq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int INDEX_MAX_DEF   = 15;

    localparam logic [2:0]  MED_TYPE   = 3'd5;
    localparam logic [23:0] PREVIEW_MS = 24'd5000;
    localparam logic [15:0] MS_PER_MIN = 16'(60 * 1000);

    localparam int S_DATA_W = 96;
    localparam int M_DATA_W = 56;

    typedef enum logic [2:0] {
        CMD_ENQ    = 3'd0,
        CMD_TICK   = 3'd1,
        CMD_ACK    = 3'd2,
        CMD_SNOOZE = 3'd3,
        CMD_CANCEL = 3'd4,
        CMD_DND    = 3'd5,
        CMD_MED    = 3'd6,
        CMD_NOP    = 3'd7
    } rpq_cmd_t;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DROPPED = 3'd1,
        ST_FULL    = 3'd2,
        ST_DUP     = 3'd3,
        ST_NO_ACT  = 3'd4,
        ST_SNZ_REF = 3'd5
    } rpq_status_t;

    typedef struct packed {
        logic [7:0]        snz;
        logic              ack;
        logic [23:0]       disp;
        logic signed [4:0] sched;
        logic signed [4:0] item;
        logic [2:0]        etype;
    } rpq_entry_t;

    typedef struct packed {
        rpq_cmd_t    cmd;
        logic [47:0] now;
        rpq_entry_t  ent;
        logic        enable;
    } rpq_req_t;

    typedef enum logic [4:0] {
        S_IDLE, S_DISP, S_REL, S_DUP_RD, S_DUP_CHK, S_ENQ_WR, S_START,
        S_MED_RD, S_MED_CHK, S_SH_RD, S_SH_WR, S_HEAD_RD, S_HEAD_CHK,
        S_ACT, S_PUR_RD, S_PUR_CHK, S_OUT
    } rpq_state_t;

    function automatic logic key_eq(input rpq_entry_t a, input rpq_entry_t b);
        return (a.etype == b.etype) && (a.item == b.item) && (a.sched == b.sched);
    endfunction

endpackage

// ----- rtl/rpq_mem.sv -----
module rpq_mem #(
    parameter int DEPTH = rpq_pkg::QUEUE_DEPTH_DEF,
    parameter int AW    = $clog2(rpq_pkg::QUEUE_DEPTH_DEF)
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  rpq_pkg::rpq_entry_t wr_data,
    input  logic [AW-1:0]       rd_addr,
    output rpq_pkg::rpq_entry_t rd_data
);
    import rpq_pkg::*;

    rpq_entry_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- rtl/reminder_priority_queue.sv -----
// Reminder priority queue.
// Input channel (s_*): one request per handshake; s_tuser carries the command,
// s_tdata the time stamp and the entry fields. Output channel (m_*): exactly
// one result per request, carrying status, event flags, the active entry and
// the queue state after the request.
// Requests are processed one at a time by a sequencer around a queue memory
// with one write port and one read port (registered read data). Enqueue scans
// the queue for a duplicate; activation searches for a medication entry and
// closes the gap behind it, or else, outside medication mode, takes the head
// entry; a tick that also releases a snooze adds a duplicate scan; and a
// do-not-disturb purge compacts the queue in place.
// s_tready is high only while the sequencer is idle; a new request can be
// taken while the previous result still waits in the output register, and
// the sequencer holds a finished result until m_tready frees that register.
// Reset (aresetn low, synchronous) empties the queue, clears the active and
// snooze slots, the preview run and both modes. Queue memory is not cleared:
// only entries that were written are ever read.
module reminder_priority_queue #(
    parameter int QUEUE_DEPTH = rpq_pkg::QUEUE_DEPTH_DEF,
    parameter int INDEX_MAX   = rpq_pkg::INDEX_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // now_ms[47:0], entry_type[50:48], entry_item[55:51], entry_schedule[60:56],
    // entry_display_ms[84:61], entry_needs_ack[85], entry_snooze_min[93:86],
    // enable[94], zero[95]
    input  logic [rpq_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd[2:0]
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0], started[3], finished[4], missed[5], active_valid[6],
    // active_type[9:7], active_item[14:10], active_schedule[19:15],
    // active_display_ms[43:20], active_needs_ack[44], queued_count[49:45],
    // preview_on[50], zero[55:51]
    output logic [rpq_pkg::M_DATA_W-1:0]  m_tdata
);
    import rpq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [FW-1:0] DEPTH_F = FW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST_A  = AW'(QUEUE_DEPTH - 1);

    rpq_state_t  state_reg, state_next;
    rpq_req_t    req_reg, req_next;
    rpq_entry_t  act_reg, act_next, snz_reg, snz_next;
    rpq_entry_t  cand_reg, cand_next, nxt_reg, nxt_next;
    logic        act_valid_reg, act_valid_next, snz_valid_reg, snz_valid_next;
    logic [47:0] act_start_reg, act_start_next, snz_due_reg, snz_due_next;
    logic [FW-1:0] prev_left_reg, prev_left_next;
    logic        prev_flag_reg, prev_flag_next;
    logic        dnd_reg, dnd_next, med_reg, med_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [FW-1:0] fill_reg, fill_next, k_reg, k_next, n_reg, n_next;
    logic        ret_start_reg, ret_start_next;
    rpq_status_t status_reg, status_next;
    logic        started_reg, started_next, fin_reg, fin_next;
    logic        missed_reg, missed_next;
    logic        m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    rpq_entry_t    mem_wdata, mem_rdata;

    rpq_mem #(.DEPTH(QUEUE_DEPTH), .AW(AW)) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                              input logic [FW-1:0] off);
        logic [FW:0] s;
        s = (FW+1)'(base) + (FW+1)'(off);
        if (s >= (FW+1)'(QUEUE_DEPTH)) begin
            s = s - (FW+1)'(QUEUE_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // out-of-range index reads as "none"
    function automatic logic signed [4:0] idx_clamp(input logic signed [4:0] v);
        logic bad;
        bad = (v[4] && v != -5'sd1) || (!v[4] && 32'(v[3:0]) > 32'(INDEX_MAX));
        return bad ? -5'sd1 : v;
    endfunction

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_A) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
        return (p == '0) ? LAST_A : p - 1'b1;
    endfunction

    // unpack the request
    rpq_req_t req_in;
    always_comb begin
        req_in.cmd       = rpq_cmd_t'(s_tuser);
        req_in.now       = s_tdata[47:0];
        req_in.ent.etype = s_tdata[50:48];
        req_in.ent.item  = idx_clamp(s_tdata[55:51]);
        req_in.ent.sched = idx_clamp(s_tdata[60:56]);
        req_in.ent.disp  = s_tdata[84:61];
        req_in.ent.ack   = s_tdata[85];
        req_in.ent.snz   = s_tdata[93:86];
        req_in.enable    = s_tdata[94];
    end

    // decision terms used by next-state and datapath logic
    logic        s_acc, out_free, q_full, q_empty;
    logic        enq_drop, enq_dup_act, mode_same, tmo_hit, rel_due, rel_refuse;
    logic        cand_match, rd_is_med, more_k1, more_k2;
    logic [47:0] elapsed;
    logic [23:0] snz_ms;
    logic [48:0] due_sum;
    logic [FW-1:0] n_inc;

    assign s_acc       = s_tvalid && s_tready;
    assign out_free    = !m_valid_reg || m_tready;
    assign q_full      = fill_reg >= DEPTH_F;
    assign q_empty     = fill_reg == '0;
    assign enq_drop    = dnd_reg && req_reg.ent.etype != MED_TYPE;
    assign enq_dup_act = act_valid_reg && key_eq(act_reg, req_reg.ent);
    assign mode_same   = (req_reg.cmd == CMD_DND) ? (dnd_reg == req_reg.enable)
                                                  : (med_reg == req_reg.enable);
    assign elapsed     = req_reg.now - act_start_reg;
    assign tmo_hit     = act_valid_reg && act_reg.disp != '0 &&
                         elapsed >= {24'd0, act_reg.disp};
    assign rel_due     = snz_valid_reg && req_reg.now >= snz_due_reg;
    assign rel_refuse  = (dnd_reg && snz_reg.etype != MED_TYPE) || q_full ||
                         (act_valid_reg && key_eq(act_reg, snz_reg));
    assign cand_match  = key_eq(mem_rdata, cand_reg);
    assign rd_is_med   = mem_rdata.etype == MED_TYPE;
    assign more_k1     = (k_reg + 1'b1) < fill_reg;
    assign more_k2     = (k_reg + FW'(2)) < fill_reg;
    assign snz_ms      = 24'(act_reg.snz) * 24'(MS_PER_MIN);
    assign due_sum     = {1'b0, req_reg.now} + {25'd0, snz_ms};
    assign n_inc       = n_reg + (rd_is_med ? 1'b1 : 1'b0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) state_next = S_DISP;
            end
            S_DISP: begin
                case (req_reg.cmd)
                    CMD_ENQ: begin
                        if (enq_drop || q_full || enq_dup_act) state_next = S_OUT;
                        else if (q_empty) state_next = S_ENQ_WR;
                        else state_next = S_DUP_RD;
                    end
                    CMD_TICK: state_next = S_REL;
                    CMD_ACK: state_next = act_valid_reg ? S_START : S_OUT;
                    CMD_SNOOZE: begin
                        if (act_valid_reg && act_reg.etype == MED_TYPE && act_reg.snz != '0)
                            state_next = S_START;
                        else
                            state_next = S_OUT;
                    end
                    CMD_CANCEL: state_next = S_START;
                    CMD_DND: begin
                        if (!mode_same && req_reg.enable && !q_empty) state_next = S_PUR_RD;
                        else state_next = S_OUT;
                    end
                    CMD_MED: begin
                        if (!mode_same && !req_reg.enable) state_next = S_START;
                        else state_next = S_OUT;
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_REL: begin
                if (!rel_due || rel_refuse) state_next = S_START;
                else if (q_empty) state_next = S_ENQ_WR;
                else state_next = S_DUP_RD;
            end
            S_DUP_RD: state_next = S_DUP_CHK;
            S_DUP_CHK: begin
                if (cand_match) state_next = ret_start_reg ? S_START : S_OUT;
                else if (more_k1) state_next = S_DUP_RD;
                else state_next = S_ENQ_WR;
            end
            S_ENQ_WR: state_next = ret_start_reg ? S_START : S_OUT;
            S_START: begin
                if (act_valid_reg) state_next = S_OUT;
                else if (!q_empty) state_next = S_MED_RD;
                else state_next = S_OUT;
            end
            S_MED_RD: state_next = S_MED_CHK;
            S_MED_CHK: begin
                if (rd_is_med) state_next = more_k1 ? S_SH_RD : S_ACT;
                else if (more_k1) state_next = S_MED_RD;
                else if (med_reg) state_next = S_OUT;
                else state_next = S_HEAD_RD;
            end
            S_SH_RD: state_next = S_SH_WR;
            S_SH_WR: state_next = more_k2 ? S_SH_RD : S_ACT;
            S_HEAD_RD: state_next = S_HEAD_CHK;
            S_HEAD_CHK: state_next = S_ACT;
            S_ACT: state_next = S_OUT;
            S_PUR_RD: state_next = S_PUR_CHK;
            S_PUR_CHK: state_next = more_k1 ? S_PUR_RD : S_OUT;
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory port and handshake outputs
    always_comb begin
        s_tready  = state_reg == S_IDLE;
        mem_we    = 1'b0;
        mem_waddr = tail_reg;
        mem_wdata = cand_reg;
        mem_raddr = slot_of(head_reg, k_reg);
        case (state_reg)
            S_SH_RD: mem_raddr = slot_of(head_reg, k_reg + 1'b1);
            S_HEAD_RD: mem_raddr = head_reg;
            S_ENQ_WR: mem_we = 1'b1;
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = slot_of(head_reg, k_reg);
                mem_wdata = mem_rdata;
            end
            S_PUR_CHK: begin
                mem_we    = rd_is_med;
                mem_waddr = slot_of(head_reg, n_reg);
                mem_wdata = mem_rdata;
            end
            default: ;
        endcase
    end

    // datapath
    always_comb begin
        rpq_entry_t  e;
        logic [FW-1:0] left;
        logic [FW+4:0] fill_ext;

        req_next       = req_reg;
        act_next       = act_reg;
        act_valid_next = act_valid_reg;
        act_start_next = act_start_reg;
        snz_next       = snz_reg;
        snz_valid_next = snz_valid_reg;
        snz_due_next   = snz_due_reg;
        cand_next      = cand_reg;
        nxt_next       = nxt_reg;
        prev_left_next = prev_left_reg;
        prev_flag_next = prev_flag_reg;
        dnd_next       = dnd_reg;
        med_next       = med_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        k_next         = k_reg;
        n_next         = n_reg;
        ret_start_next = ret_start_reg;
        status_next    = status_reg;
        started_next   = started_reg;
        fin_next       = fin_reg;
        missed_next    = missed_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        e              = nxt_reg;
        left           = prev_left_reg;
        fill_ext       = {5'd0, fill_reg};

        if (m_valid_reg && m_tready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    req_next       = req_in;
                    status_next    = ST_OK;
                    started_next   = 1'b0;
                    fin_next       = 1'b0;
                    missed_next    = 1'b0;
                    ret_start_next = 1'b0;
                    k_next         = '0;
                    n_next         = '0;
                end
            end
            S_DISP: begin
                cand_next = req_reg.ent;
                case (req_reg.cmd)
                    CMD_ENQ: begin
                        if (enq_drop) status_next = ST_DROPPED;
                        else if (q_full) status_next = ST_FULL;
                        else if (enq_dup_act) status_next = ST_DUP;
                    end
                    CMD_TICK: begin
                        if (tmo_hit) begin
                            missed_next    = act_reg.ack;
                            fin_next       = 1'b1;
                            act_valid_next = 1'b0;
                            act_next       = '0;
                            act_start_next = '0;
                        end
                    end
                    CMD_ACK: begin
                        if (!act_valid_reg) begin
                            status_next = ST_NO_ACT;
                        end else begin
                            prev_left_next = fill_reg;
                            prev_flag_next = !q_empty;
                            fin_next       = 1'b1;
                            act_valid_next = 1'b0;
                            act_next       = '0;
                            act_start_next = '0;
                        end
                    end
                    CMD_SNOOZE: begin
                        if (!act_valid_reg) begin
                            status_next = ST_NO_ACT;
                        end else if (act_reg.etype != MED_TYPE || act_reg.snz == '0) begin
                            status_next = ST_SNZ_REF;
                        end else begin
                            snz_next       = act_reg;
                            snz_valid_next = 1'b1;
                            snz_due_next   = due_sum[48] ? '1 : due_sum[47:0];
                            fin_next       = 1'b1;
                            act_valid_next = 1'b0;
                            act_next       = '0;
                            act_start_next = '0;
                        end
                    end
                    CMD_CANCEL: begin
                        if (act_valid_reg) begin
                            fin_next       = 1'b1;
                            act_valid_next = 1'b0;
                            act_next       = '0;
                            act_start_next = '0;
                        end
                    end
                    CMD_DND: begin
                        if (!mode_same) begin
                            dnd_next = req_reg.enable;
                            if (req_reg.enable) begin
                                prev_flag_next = 1'b0;
                                prev_left_next = '0;
                            end
                        end
                    end
                    CMD_MED: begin
                        if (!mode_same) med_next = req_reg.enable;
                    end
                    default: ;
                endcase
            end
            S_REL: begin
                // due snooze goes back through the enqueue checks; refusal loses it
                if (rel_due) begin
                    snz_valid_next = 1'b0;
                    cand_next      = snz_reg;
                    ret_start_next = 1'b1;
                end
            end
            S_DUP_CHK: begin
                if (cand_match) begin
                    if (!ret_start_reg) status_next = ST_DUP;
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_ENQ_WR: begin
                tail_next = ptr_inc(tail_reg);
                fill_next = fill_reg + 1'b1;
            end
            S_START: begin
                k_next = '0;
                if (!act_valid_reg && q_empty && !med_reg) begin
                    prev_flag_next = 1'b0;
                    prev_left_next = '0;
                end
            end
            S_MED_CHK: begin
                if (rd_is_med) begin
                    nxt_next = mem_rdata;
                    if (!more_k1) begin
                        tail_next = ptr_dec(tail_reg);
                        fill_next = fill_reg - 1'b1;
                    end
                end else begin
                    k_next = k_reg + 1'b1;
                end
            end
            S_SH_WR: begin
                k_next = k_reg + 1'b1;
                if (!more_k2) begin
                    tail_next = ptr_dec(tail_reg);
                    fill_next = fill_reg - 1'b1;
                end
            end
            S_HEAD_CHK: begin
                nxt_next  = mem_rdata;
                head_next = ptr_inc(head_reg);
                fill_next = fill_reg - 1'b1;
            end
            S_ACT: begin
                if (prev_flag_reg && prev_left_reg != '0) begin
                    e.disp = PREVIEW_MS;
                    e.ack  = 1'b0;
                    e.snz  = '0;
                    left   = prev_left_reg - 1'b1;
                end
                prev_left_next = left;
                if (prev_flag_reg && left == '0) prev_flag_next = 1'b0;
                act_next       = e;
                act_valid_next = 1'b1;
                act_start_next = req_reg.now;
                started_next   = 1'b1;
            end
            S_PUR_CHK: begin
                // in-place compaction relative to head keeps logical order
                n_next = n_inc;
                k_next = k_reg + 1'b1;
                if (!more_k1) begin
                    fill_next = n_inc;
                    tail_next = slot_of(head_reg, n_inc);
                end
            end
            S_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '0;
                    m_data_next[2:0]   = status_reg;
                    m_data_next[3]     = started_reg;
                    m_data_next[4]     = fin_reg;
                    m_data_next[5]     = missed_reg;
                    m_data_next[6]     = act_valid_reg;
                    m_data_next[9:7]   = act_valid_reg ? act_reg.etype : 3'd0;
                    m_data_next[14:10] = act_valid_reg ? act_reg.item : -5'sd1;
                    m_data_next[19:15] = act_valid_reg ? act_reg.sched : -5'sd1;
                    m_data_next[43:20] = act_valid_reg ? act_reg.disp : 24'd0;
                    m_data_next[44]    = act_valid_reg && act_reg.ack;
                    m_data_next[49:45] = fill_ext[4:0];
                    m_data_next[50]    = prev_flag_reg || (act_valid_reg && !act_reg.ack &&
                                         act_reg.disp == PREVIEW_MS);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            act_valid_reg <= 1'b0;
            act_reg       <= '0;
            act_start_reg <= '0;
            snz_valid_reg <= 1'b0;
            snz_reg       <= '0;
            snz_due_reg   <= '0;
            prev_left_reg <= '0;
            prev_flag_reg <= 1'b0;
            dnd_reg       <= 1'b0;
            med_reg       <= 1'b0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            act_valid_reg <= act_valid_next;
            act_reg       <= act_next;
            act_start_reg <= act_start_next;
            snz_valid_reg <= snz_valid_next;
            snz_reg       <= snz_next;
            snz_due_reg   <= snz_due_next;
            prev_left_reg <= prev_left_next;
            prev_flag_reg <= prev_flag_next;
            dnd_reg       <= dnd_next;
            med_reg       <= med_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        cand_reg      <= cand_next;
        nxt_reg       <= nxt_next;
        k_reg         <= k_next;
        n_reg         <= n_next;
        ret_start_reg <= ret_start_next;
        status_reg    <= status_next;
        started_reg   <= started_next;
        fin_reg       <= fin_next;
        missed_reg    <= missed_next;
        m_data_reg    <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- rtl/rpq_checker.sv -----
module rpq_props (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata
);
    import rpq_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_idle_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[6] |->
            m_tdata[19:10] == 10'h3FF && m_tdata[9:7] == 3'd0 &&
            m_tdata[43:20] == 24'd0 && !m_tdata[44])
        else $error("inactive slot shows entry fields");

    a_miss_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[4])
        else $error("miss without finish");

    a_start_act: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[6] && m_tdata[2:0] == ST_OK)
        else $error("start with refusal status or no active entry");

endmodule

bind reminder_priority_queue rpq_props u_rpq_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
